/* src/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Both macros expect clk_i, and CST_ASSERT also rst_ni, to exist in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that is also checked across the reset release.
`define CST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/cst_pkg.sv */
// Package of the contact search trigger: sizes, field widths, register codes
// and the types passed between its modules. Depends on nothing.
`default_nettype none

package cst_pkg;

  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned DIMENSIONS    = 3;

  localparam int unsigned ADDR_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VEL_W   = 32;
  localparam int unsigned REG_W   = 31;
  localparam int unsigned DISP_W  = 32;
  localparam int unsigned PEAK_W  = 31;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned MUL_W   = VEL_W + REG_W + 1;
  localparam int unsigned STEP_W  = MUL_W - FRAC_W;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned ROW_W   = DIMENSIONS * DISP_W;
  localparam int unsigned CFG_IDX_W = 3;

  // Threshold arithmetic widths.
  localparam int unsigned A_W    = 2 * REG_W - FRAC_W;
  localparam int unsigned A_LO_W = A_W / 2;
  localparam int unsigned A_HI_W = A_W - A_LO_W;
  localparam int unsigned PP_W   = A_HI_W + REG_W;
  localparam int unsigned PROD_W = 49;
  localparam int unsigned RHS_W  = REG_W + 3;

  localparam logic [REG_W-1:0]  Q_ONE    = REG_W'(65536);
  localparam logic [PROD_W-1:0] PROD_SAT = {1'b1, {(PROD_W-1){1'b0}}};
  localparam logic [PEAK_W-1:0] PEAK_MAX = '1;
  localparam logic signed [DISP_W-1:0] DISP_MAX = {1'b0, {(DISP_W-1){1'b1}}};
  localparam logic signed [DISP_W-1:0] DISP_MIN = {1'b1, {(DISP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = 3'd0,
    CFG_NEIGH_RATIO   = 3'd1,
    CFG_MIN_CELL_SIZE = 3'd2,
    CFG_MAX_DIAMETER  = 3'd3,
    CFG_SEARCH_FACTOR = 3'd4
  } cfg_reg_e;

  typedef logic [ADDR_W-1:0]                  addr_t;
  typedef logic [EPOCH_W-1:0]                 epoch_t;
  typedef logic signed [DISP_W-1:0]           disp_t;
  typedef disp_t [DIMENSIONS-1:0]             disp_row_t;
  typedef logic [DIMENSIONS-1:0][VEL_W-1:0]   vel_row_t;

  // Thresholds derived from the configuration registers.
  typedef struct packed {
    logic [REG_W-1:0]        time_step;
    logic                    ratio_le_one;
    logic signed [RHS_W-1:0] cell_rhs;
    logic [PROD_W-1:0]       factor_prod;
  } limits_t;

  // One item after its displacement update.
  typedef struct packed {
    logic      valid;
    logic      last;
    logic      upd;
    disp_row_t disp;
  } upd_stage_t;

  // End-of-pass decision, valid for one cycle when fire is set.
  typedef struct packed {
    logic fire;
    logic hit;
  } verdict_t;

endpackage

`default_nettype wire

/* src/cst_in_if.sv */
// Input channel of the contact search trigger: one particle per beat.
// Depends on cst_pkg for the field widths.
`default_nettype none

interface cst_in_if;
  logic                                valid;
  logic                                ready;
  logic [cst_pkg::IDX_W-1:0]           particle_index;
  logic signed [cst_pkg::VEL_W-1:0]    velocity_x;
  logic signed [cst_pkg::VEL_W-1:0]    velocity_y;
  logic signed [cst_pkg::VEL_W-1:0]    velocity_z;
  logic                                pass_end;

  modport source (
    output valid, particle_index, velocity_x, velocity_y, velocity_z, pass_end,
    input  ready
  );
  modport sink (
    input  valid, particle_index, velocity_x, velocity_y, velocity_z, pass_end,
    output ready
  );
endinterface

`default_nettype wire

/* src/cst_out_if.sv */
// Result channel of the contact search trigger: one verdict per beat.
// Depends on cst_pkg for the field widths.
`default_nettype none

interface cst_out_if;
  logic                       valid;
  logic                       ready;
  logic                       search_needed;
  logic [cst_pkg::PEAK_W-1:0] peak_displacement;

  modport source (output valid, search_needed, peak_displacement, input ready);
  modport sink   (input  valid, search_needed, peak_displacement, output ready);
endinterface

`default_nettype wire

/* src/cst_thresh.sv */
// Configuration registers and the pipelined threshold arithmetic derived from them.
// Depends on cst_pkg.
`default_nettype none

module cst_thresh (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cst_pkg::REG_W-1:0]       cfg_data_i,
  output cst_pkg::limits_t                limits_o
);

  logic [cst_pkg::REG_W-1:0] ts_q, ratio_q, cell_q, diam_q, factor_q;

  logic [cst_pkg::A_W-1:0]    a_q;
  logic [cst_pkg::PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic [cst_pkg::PROD_W-1:0] prod_q;
  logic signed [cst_pkg::RHS_W-1:0] rhs_q;

  logic [cst_pkg::REG_W-1:0]   ratio_excess;
  logic [2*cst_pkg::REG_W-1:0] a_full;
  logic [cst_pkg::PP_W:0]      prod_sum;
  logic                        hi_over;
  logic                        sum_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q     <= '0;
      ratio_q  <= cst_pkg::Q_ONE;
      cell_q   <= '0;
      diam_q   <= '0;
      factor_q <= cst_pkg::Q_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cst_pkg::CFG_TIME_STEP:     ts_q     <= cfg_data_i;
        cst_pkg::CFG_NEIGH_RATIO:   ratio_q  <= cfg_data_i;
        cst_pkg::CFG_MIN_CELL_SIZE: cell_q   <= cfg_data_i;
        cst_pkg::CFG_MAX_DIAMETER:  diam_q   <= cfg_data_i;
        cst_pkg::CFG_SEARCH_FACTOR: factor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Only meaningful when the ratio is above one; otherwise the search always fires.
  assign ratio_excess = ratio_q - cst_pkg::Q_ONE;
  assign a_full = (2*cst_pkg::REG_W)'(factor_q) * (2*cst_pkg::REG_W)'(ratio_excess);

  // The product a * diameter is 77 bits wide, so it is built from two halves of a.
  assign hi_over  = |pp_hi_q[cst_pkg::PP_W-1:cst_pkg::PROD_W-1-cst_pkg::A_LO_W];
  assign prod_sum = (cst_pkg::PP_W+1)'({pp_hi_q[cst_pkg::PROD_W-2-cst_pkg::A_LO_W:0],
                                        {cst_pkg::A_LO_W{1'b0}}})
                  + (cst_pkg::PP_W+1)'(pp_lo_q);
  assign sum_over = |prod_sum[cst_pkg::PP_W:cst_pkg::PROD_W-1];

  always_ff @(posedge clk_i) begin
    a_q     <= a_full[2*cst_pkg::REG_W-1:cst_pkg::FRAC_W];
    pp_lo_q <= cst_pkg::PP_W'(a_q[cst_pkg::A_LO_W-1:0]) * cst_pkg::PP_W'(diam_q);
    pp_hi_q <= cst_pkg::PP_W'(a_q[cst_pkg::A_W-1:cst_pkg::A_LO_W]) * cst_pkg::PP_W'(diam_q);
    prod_q  <= (hi_over || sum_over) ? cst_pkg::PROD_SAT
                                     : cst_pkg::PROD_W'(prod_sum[cst_pkg::PROD_W-2:0]);
    rhs_q   <= $signed({2'b00, cell_q, 1'b0}) - $signed({3'b000, diam_q});
  end

  assign limits_o.time_step    = ts_q;
  assign limits_o.ratio_le_one = (ratio_q <= cst_pkg::Q_ONE);
  assign limits_o.cell_rhs     = rhs_q;
  assign limits_o.factor_prod  = prod_q;

endmodule

`default_nettype wire

/* src/cst_disp_mem.sv */
// Displacement store: read, saturating update and write-back of one particle row
// per cycle, with an epoch tag per row and a clearing sweep. Depends on cst_pkg.
`default_nettype none

module cst_disp_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [cst_pkg::IDX_W-1:0]   idx_i,
  input  cst_pkg::vel_row_t           vel_i,
  input  logic                        last_i,
  input  logic [cst_pkg::REG_W-1:0]   time_step_i,
  input  cst_pkg::verdict_t           verdict_i,
  output logic                        sweep_o,
  output cst_pkg::upd_stage_t         stage_o
);

  localparam cst_pkg::addr_t SweepLast = cst_pkg::addr_t'(cst_pkg::MAX_PARTICLES - 1);

  cst_pkg::disp_row_t disp_mem [cst_pkg::MAX_PARTICLES];
  cst_pkg::epoch_t    tag_mem  [cst_pkg::MAX_PARTICLES];

  function automatic cst_pkg::disp_t sat_add(cst_pkg::disp_t a,
                                             logic signed [cst_pkg::STEP_W-1:0] b);
    logic signed [cst_pkg::STEP_W:0] s;
    logic [cst_pkg::STEP_W-cst_pkg::DISP_W+1:0] top;
    s   = $signed({{(cst_pkg::STEP_W+1-cst_pkg::DISP_W){a[cst_pkg::DISP_W-1]}}, a})
        + $signed({b[cst_pkg::STEP_W-1], b});
    top = s[cst_pkg::STEP_W:cst_pkg::DISP_W-1];
    if (top == '0 || top == '1) begin
      return s[cst_pkg::DISP_W-1:0];
    end else if (s[cst_pkg::STEP_W]) begin
      return cst_pkg::DISP_MIN;
    end else begin
      return cst_pkg::DISP_MAX;
    end
  endfunction

  logic                  in_range;
  cst_pkg::addr_t        rd_addr;
  logic signed [cst_pkg::STEP_W-1:0] step_d [cst_pkg::DIMENSIONS];

  // Read stage registers.
  logic                  s1_v_q, s1_upd_q, s1_last_q;
  cst_pkg::addr_t        s1_addr_q;
  logic signed [cst_pkg::STEP_W-1:0] s1_step_q [cst_pkg::DIMENSIONS];
  cst_pkg::disp_row_t    rd_row_q;
  cst_pkg::epoch_t       rd_tag_q;

  // Copy of the last item write, for a row read in the same cycle it was written.
  logic                  fwd_v_q;
  cst_pkg::addr_t        fwd_addr_q;
  cst_pkg::disp_row_t    fwd_row_q;
  cst_pkg::epoch_t       fwd_tag_q;

  // Update stage registers.
  logic                  s2_v_q, s2_upd_q, s2_last_q;
  cst_pkg::disp_row_t    s2_row_q;

  cst_pkg::epoch_t       epoch_q;
  logic                  sweep_q;
  cst_pkg::addr_t        sweep_cnt_q;

  cst_pkg::disp_row_t    base_row, new_row;
  cst_pkg::epoch_t       base_tag;
  logic                  fresh;
  logic                  item_wr, wr_en;
  cst_pkg::addr_t        wr_addr;
  cst_pkg::disp_row_t    wr_row;

  assign in_range = (32'(idx_i) < cst_pkg::MAX_PARTICLES);
  assign rd_addr  = cst_pkg::addr_t'(idx_i);

  // Velocity times time step, Q32.32 taken down to Q32.16 by an arithmetic shift
  // (rounds toward minus infinity).
  always_comb begin
    logic signed [cst_pkg::MUL_W-1:0] prod;
    for (int d = 0; d < cst_pkg::DIMENSIONS; d++) begin
      prod      = $signed(vel_i[d]) * $signed({1'b0, time_step_i});
      step_d[d] = prod[cst_pkg::MUL_W-1:cst_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_upd_q  <= in_range;
      s1_last_q <= last_i;
      s1_addr_q <= rd_addr;
      s1_step_q <= step_d;
    end
  end

  // A row whose tag is not the current epoch was cleared by a trigger.
  always_comb begin
    if (fwd_v_q && fwd_addr_q == s1_addr_q) begin
      base_row = fwd_row_q;
      base_tag = fwd_tag_q;
    end else begin
      base_row = rd_row_q;
      base_tag = rd_tag_q;
    end
    fresh = (base_tag == epoch_q);
    for (int d = 0; d < cst_pkg::DIMENSIONS; d++) begin
      new_row[d] = sat_add(fresh ? base_row[d] : '0, s1_step_q[d]);
    end
  end

  // Items and the sweep never overlap: no item is accepted while sweeping.
  assign item_wr = s1_v_q && s1_upd_q;
  assign wr_en   = item_wr || sweep_q;
  assign wr_addr = sweep_q ? sweep_cnt_q : s1_addr_q;
  assign wr_row  = sweep_q ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (accept_i && in_range) begin
      rd_row_q <= disp_mem[rd_addr];
      rd_tag_q <= tag_mem[rd_addr];
    end
    if (wr_en) begin
      disp_mem[wr_addr] <= wr_row;
      tag_mem[wr_addr]  <= epoch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      fwd_v_q <= item_wr;
      s2_v_q  <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_wr) begin
      fwd_addr_q <= s1_addr_q;
      fwd_row_q  <= new_row;
      fwd_tag_q  <= epoch_q;
    end
    if (s1_v_q) begin
      s2_upd_q  <= s1_upd_q;
      s2_last_q <= s1_last_q;
      s2_row_q  <= new_row;
    end
  end

  // Each trigger moves to a new epoch; when the tag wraps, old tags could match
  // again, so the whole store is swept to zero as it is after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= '0;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
    end else begin
      if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == SweepLast) begin
          sweep_q <= 1'b0;
        end
      end
      if (verdict_i.fire && verdict_i.hit) begin
        epoch_q <= epoch_q + 1'b1;
        if (&epoch_q) begin
          sweep_q     <= 1'b1;
          sweep_cnt_q <= '0;
        end
      end
    end
  end

  assign sweep_o       = sweep_q;
  assign stage_o.valid = s2_v_q;
  assign stage_o.last  = s2_last_q;
  assign stage_o.upd   = s2_upd_q;
  assign stage_o.disp  = s2_row_q;

endmodule

`default_nettype wire

/* src/cst_peak_judge.sv */
// Running peak of absolute displacement, end-of-pass trigger decision and the
// result register. Depends on cst_pkg.
`default_nettype none

module cst_peak_judge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cst_pkg::upd_stage_t         stage_i,
  input  cst_pkg::limits_t            limits_i,
  input  logic                        out_ready_i,
  output cst_pkg::verdict_t           verdict_o,
  output logic                        out_valid_o,
  output logic                        search_needed_o,
  output logic [cst_pkg::PEAK_W-1:0]  peak_o
);

  function automatic logic [cst_pkg::PEAK_W-1:0] abs_sat(cst_pkg::disp_t x);
    logic [cst_pkg::DISP_W-1:0] nx;
    nx = -x;
    if (x == cst_pkg::DISP_MIN) begin
      return cst_pkg::PEAK_MAX;
    end else if (x[cst_pkg::DISP_W-1]) begin
      return nx[cst_pkg::PEAK_W-1:0];
    end else begin
      return x[cst_pkg::PEAK_W-1:0];
    end
  endfunction

  logic [cst_pkg::PEAK_W-1:0] item_max;
  logic                       s3_v_q, s3_upd_q, s3_last_q;
  logic [cst_pkg::PEAK_W-1:0] s3_mag_q;
  logic [cst_pkg::PEAK_W-1:0] run_q, pass_peak;
  logic                       pend_v_q;
  logic [cst_pkg::PEAK_W-1:0] pend_peak_q;
  logic                       out_v_q, out_hit_q;
  logic [cst_pkg::PEAK_W-1:0] out_peak_q;
  logic                       issue, cell_hit, factor_hit, hit;

  always_comb begin
    logic [cst_pkg::PEAK_W-1:0] m;
    item_max = '0;
    for (int d = 0; d < cst_pkg::DIMENSIONS; d++) begin
      m = abs_sat(stage_i.disp[d]);
      if (m > item_max) begin
        item_max = m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.valid) begin
      s3_upd_q  <= stage_i.upd;
      s3_last_q <= stage_i.last;
      s3_mag_q  <= item_max;
    end
  end

  assign pass_peak = (s3_upd_q && s3_mag_q > run_q) ? s3_mag_q : run_q;

  // The decision waits here while the result register is still occupied.
  assign issue      = pend_v_q && (!out_v_q || out_ready_i);
  assign cell_hit   = $signed({2'b00, pend_peak_q, 1'b0}) >= limits_i.cell_rhs;
  assign factor_hit = {1'b0, pend_peak_q, 17'd0} >= limits_i.factor_prod;
  assign hit        = cell_hit || limits_i.ratio_le_one || factor_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (issue) begin
        pend_v_q <= 1'b0;
      end
      if (s3_v_q) begin
        if (s3_last_q) begin
          run_q    <= '0;
          pend_v_q <= 1'b1;
        end else begin
          run_q <= pass_peak;
        end
      end
      if (issue) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && s3_last_q) begin
      pend_peak_q <= pass_peak;
    end
    if (issue) begin
      out_hit_q  <= hit;
      out_peak_q <= pend_peak_q;
    end
  end

  assign verdict_o.fire = issue;
  assign verdict_o.hit  = hit;
  assign out_valid_o     = out_v_q;
  assign search_needed_o = out_hit_q;
  assign peak_o          = out_peak_q;

endmodule

`default_nettype wire

/* src/contact_search_trigger.sv */
// Contact search trigger, top level. Each input beat carries one particle: its
// index, its velocity and a mark for the last particle of the time step. The
// block adds velocity times time step to that particle's stored displacement on
// each axis (saturating Q16.16), tracks the largest absolute axis displacement
// of the pass, and on the marked beat sends one result beat: whether a contact
// search is needed, and the peak. A positive decision clears all stored
// displacements at once by advancing an epoch tag kept with each row of the
// store. Ordinary particles are taken one per clock: the store is a single-port
// read memory, written back next cycle, with forwarding between neighbor beats.
// A beat marked as last closes the pass: no new beat is taken while the decision
// travels down the pipeline, and longer if the previous result has not yet been
// taken. The result then waits in a register, so input keeps flowing while it is
// held. After reset, and after every 256th positive decision when the epoch tag
// wraps, a clearing pass writes every row, one per cycle, all MAX_PARTICLES
// (1024) of them; no input beat is taken meanwhile, configuration writes are.
// Configuration registers are written through the plain write port and must
// only be changed while no pass is in flight.
`default_nettype none

module contact_search_trigger (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  cst_in_if.sink                          in_i,
  cst_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cst_pkg::REG_W-1:0]       cfg_data_i
);

  cst_pkg::limits_t    limits;
  cst_pkg::verdict_t   verdict;
  cst_pkg::upd_stage_t stage;
  cst_pkg::vel_row_t   vel;
  logic                sweeping;
  logic                accept;
  logic                busy_q;

  // A pass-closing beat holds the input until its decision is made, so that the
  // next pass sees the store already cleared when the search fires.
  assign in_i.ready = !busy_q && !sweeping;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (accept && in_i.pass_end) begin
      busy_q <= 1'b1;
    end else if (verdict.fire) begin
      busy_q <= 1'b0;
    end
  end

  // In two dimensions the z component is simply not used.
  always_comb begin
    for (int d = 0; d < cst_pkg::DIMENSIONS; d++) begin
      case (d)
        0:       vel[d] = in_i.velocity_x;
        1:       vel[d] = in_i.velocity_y;
        default: vel[d] = in_i.velocity_z;
      endcase
    end
  end

  cst_thresh u_thresh (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .limits_o   (limits)
  );

  cst_disp_mem u_disp_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .idx_i       (in_i.particle_index),
    .vel_i       (vel),
    .last_i      (in_i.pass_end),
    .time_step_i (limits.time_step),
    .verdict_i   (verdict),
    .sweep_o     (sweeping),
    .stage_o     (stage)
  );

  cst_peak_judge u_peak_judge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stage_i         (stage),
    .limits_i        (limits),
    .out_ready_i     (out_o.ready),
    .verdict_o       (verdict),
    .out_valid_o     (out_o.valid),
    .search_needed_o (out_o.search_needed),
    .peak_o          (out_o.peak_displacement)
  );

endmodule

`default_nettype wire

/* src/cst_checker.sv */
// Port-level checks of the contact search trigger, bound to its top level.
// Depends on cst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cst_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       in_pass_end_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic                       out_search_needed_i,
  input  logic [cst_pkg::PEAK_W-1:0] out_peak_i
);

  // A held result beat keeps its contents.
  `CST_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_search_needed_i) && $stable(out_peak_i), "result beat changed while stalled")

  // The clearing pass after reset keeps the input closed.
  `CST_ASSERT_ALWAYS(a_reset_sweep, $rose(rst_ni) |-> !in_ready_i, "input open right after reset")

  // A pass-closing beat closes the input right after it is taken; only the start of that hold is checked.
  `CST_ASSERT(a_pass_interlock, in_valid_i && in_ready_i && in_pass_end_i |=> !in_ready_i ##1 !in_ready_i, "input reopened before the pass decision")

endmodule

bind contact_search_trigger cst_checker u_cst_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_pass_end_i       (in_i.pass_end),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_search_needed_i (out_o.search_needed),
  .out_peak_i          (out_o.peak_displacement)
);

`default_nettype wire

/* tb/contact_search_trigger_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of contact_search_trigger: directed and random particle
// passes, with every result beat compared against an in-bench displacement model.
// Depends on cst_pkg, cst_in_if, cst_out_if and the block itself.

module contact_search_trigger_tb;

  localparam int unsigned ITEM_TARGET    = 950;
  localparam int unsigned WRAP_PASSES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned QUIET_PHASE    = 3;

  // Index past the register list; writes to it must change nothing.
  localparam logic [cst_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam logic [cst_pkg::REG_W-1:0]        REG_MAX  = '1;
  localparam logic signed [cst_pkg::VEL_W-1:0] VEL_MAX  = {1'b0, {(cst_pkg::VEL_W-1){1'b1}}};
  localparam logic signed [cst_pkg::VEL_W-1:0] VEL_MIN  = {1'b1, {(cst_pkg::VEL_W-1){1'b0}}};
  localparam logic [cst_pkg::IDX_W-1:0]        IDX_LAST =
    cst_pkg::IDX_W'(cst_pkg::MAX_PARTICLES - 1);

  typedef enum int {
    PROFILE_ALWAYS,
    PROFILE_TUNED,
    PROFILE_WILD,
    PROFILE_EDGES
  } profile_e;

  typedef struct {
    logic [cst_pkg::IDX_W-1:0]        index;
    logic signed [cst_pkg::VEL_W-1:0] vx;
    logic signed [cst_pkg::VEL_W-1:0] vy;
    logic signed [cst_pkg::VEL_W-1:0] vz;
    logic                             pass_end;
  } particle_t;

  typedef struct {
    logic                       search_needed;
    logic [cst_pkg::PEAK_W-1:0] peak;
  } search_result_t;

  logic clk_i;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [cst_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cst_pkg::REG_W-1:0]     cfg_data_i;

  cst_in_if  in_if ();
  cst_out_if out_if ();

  contact_search_trigger i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [cst_pkg::REG_W-1:0] step_reg   = '0;
  logic [cst_pkg::REG_W-1:0] ratio_reg  = cst_pkg::Q_ONE;
  logic [cst_pkg::REG_W-1:0] cell_reg   = '0;
  logic [cst_pkg::REG_W-1:0] diam_reg   = '0;
  logic [cst_pkg::REG_W-1:0] factor_reg = cst_pkg::Q_ONE;

  // Model of the displacement store. A row that is not live reads as zero, which
  // stands in for the epoch tags of the block.
  cst_pkg::disp_t             disp_mem [cst_pkg::MAX_PARTICLES][3];
  bit                         row_live [cst_pkg::MAX_PARTICLES];
  logic [cst_pkg::PEAK_W-1:0] pass_peak = '0;

  search_result_t pending_verdicts [$];

  int unsigned items_sent   = 0;
  int unsigned errors       = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idling    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Decision at the end of a pass: cell-size limit first, then a ratio of at most
  // one, then the search-factor limit, all evaluated exactly in 64-bit arithmetic.
  function automatic bit search_decision(logic [cst_pkg::PEAK_W-1:0] peak);
    longint signed   twice_peak;
    longint signed   cell_bound;
    longint unsigned ratio_w;
    longint unsigned factor_w;
    longint unsigned diam_w;
    longint unsigned peak_w;
    longint unsigned factor_a;
    twice_peak = 2 * longint'(peak);
    cell_bound = 2 * longint'(cell_reg) - longint'(diam_reg);
    if (twice_peak >= cell_bound) return 1'b1;
    if (ratio_reg <= cst_pkg::Q_ONE) return 1'b1;
    ratio_w  = ratio_reg;
    factor_w = factor_reg;
    diam_w   = diam_reg;
    peak_w   = peak;
    factor_a = (factor_w * (ratio_w - cst_pkg::Q_ONE)) >> cst_pkg::FRAC_W;
    if (factor_a == 0 || diam_w == 0) return 1'b1;
    // A threshold product past 2^48 can never be reached by the peak.
    if (factor_a > ((64'd1 << 48) - 1) / diam_w) return 1'b0;
    return (peak_w << (cst_pkg::FRAC_W + 1)) >= factor_a * diam_w;
  endfunction

  // Applies one accepted particle to the model and queues the verdict that a
  // marked beat produces.
  function automatic void accumulate_particle(particle_t beat);
    longint signed  lane [3];
    longint signed  sum;
    longint signed  mag;
    int             d;
    search_result_t verdict;
    lane[0] = beat.vx;
    lane[1] = beat.vy;
    lane[2] = beat.vz;
    // Indices past the store update nothing but still close a pass.
    if (beat.index < cst_pkg::MAX_PARTICLES) begin
      if (!row_live[beat.index]) begin
        for (d = 0; d < 3; d++) disp_mem[beat.index][d] = '0;
        row_live[beat.index] = 1'b1;
      end
      for (d = 0; d < cst_pkg::DIMENSIONS && d < 3; d++) begin
        // Q32.32 product, arithmetic shift rounds toward minus infinity.
        sum = longint'(disp_mem[beat.index][d]) +
              ((lane[d] * longint'(step_reg)) >>> cst_pkg::FRAC_W);
        if (sum > longint'(cst_pkg::DISP_MAX)) sum = longint'(cst_pkg::DISP_MAX);
        if (sum < longint'(cst_pkg::DISP_MIN)) sum = longint'(cst_pkg::DISP_MIN);
        disp_mem[beat.index][d] = cst_pkg::disp_t'(sum);
        mag = (sum < 0) ? -sum : sum;
        if (mag > longint'(cst_pkg::DISP_MAX)) mag = longint'(cst_pkg::DISP_MAX);
        if (mag > longint'(pass_peak)) pass_peak = mag[cst_pkg::PEAK_W-1:0];
      end
    end
    if (beat.pass_end) begin
      verdict.peak          = pass_peak;
      verdict.search_needed = search_decision(pass_peak);
      if (verdict.search_needed) begin
        for (d = 0; d < cst_pkg::MAX_PARTICLES; d++) row_live[d] = 1'b0;
      end
      pass_peak = '0;
      pending_verdicts.push_back(verdict);
    end
  endfunction

  // Result side: ready idles about one cycle in ten unless a quiet stretch runs.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= no_idling || ($urandom_range(99) >= 10);
    end
  end

  // Every result beat is matched against the oldest pending verdict.
  always @(posedge clk_i) begin : check_results
    search_result_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got search_needed=%0b peak=%0d",
                 $time, out_if.search_needed, out_if.peak_displacement);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_if.search_needed !== want.search_needed) begin
          $display("%0t: search_needed mismatch, expected %0b, got %0b",
                   $time, want.search_needed, out_if.search_needed);
          errors++;
        end
        if (out_if.peak_displacement !== want.peak) begin
          $display("%0t: peak_displacement mismatch, expected %0d, got %0d",
                   $time, want.peak, out_if.peak_displacement);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  // The limit covers the clearing pass several times over.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // All driving tasks start and end at a falling edge. Valid stays high on
  // return so back-to-back beats never lower and raise it in one step.
  task automatic send_particle(input logic [cst_pkg::IDX_W-1:0] index,
                               input logic signed [cst_pkg::VEL_W-1:0] vx,
                               input logic signed [cst_pkg::VEL_W-1:0] vy,
                               input logic signed [cst_pkg::VEL_W-1:0] vz,
                               input logic pass_end);
    particle_t beat;
    beat.index    = index;
    beat.vx       = vx;
    beat.vy       = vy;
    beat.vz       = vz;
    beat.pass_end = pass_end;
    if (!no_idling && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.particle_index <= index;
    in_if.velocity_x     <= vx;
    in_if.velocity_y     <= vy;
    in_if.velocity_z     <= vz;
    in_if.pass_end       <= pass_end;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    accumulate_particle(beat);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Drops valid, waits for every pending verdict, then lets the pipeline empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [cst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cst_pkg::REG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  // Writes all five registers in consecutive cycles, preceded by a write to the
  // spare index that the block must ignore. Only called with the block idle.
  task automatic write_registers(input logic [cst_pkg::REG_W-1:0] step,
                                 input logic [cst_pkg::REG_W-1:0] ratio,
                                 input logic [cst_pkg::REG_W-1:0] cell_size,
                                 input logic [cst_pkg::REG_W-1:0] diam,
                                 input logic [cst_pkg::REG_W-1:0] factor);
    cfg_write(CFG_IDX_SPARE, cst_pkg::REG_W'($urandom));
    cfg_write(cst_pkg::CFG_TIME_STEP, step);
    cfg_write(cst_pkg::CFG_NEIGH_RATIO, ratio);
    cfg_write(cst_pkg::CFG_MIN_CELL_SIZE, cell_size);
    cfg_write(cst_pkg::CFG_MAX_DIAMETER, diam);
    cfg_write(cst_pkg::CFG_SEARCH_FACTOR, factor);
    cfg_we_i   <= 1'b0;
    step_reg   = step;
    ratio_reg  = ratio;
    cell_reg   = cell_size;
    diam_reg   = diam;
    factor_reg = factor;
  endtask

  // Mostly small velocities so displacements build up over passes, plus full
  // random words and the extremes of the field.
  function automatic logic signed [cst_pkg::VEL_W-1:0] pick_velocity();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return cst_pkg::VEL_W'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    if (roll < 85) return cst_pkg::VEL_W'($urandom);
    case ($urandom_range(4))
      0: return VEL_MAX;
      1: return VEL_MIN;
      2: return '0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // A small pool of hot particles, full-range picks, and the two end rows.
  function automatic logic [cst_pkg::IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return cst_pkg::IDX_W'($urandom_range(15));
    if (roll < 85) return cst_pkg::IDX_W'($urandom);
    return roll[0] ? IDX_LAST : cst_pkg::IDX_W'(0);
  endfunction

  function automatic logic [cst_pkg::REG_W-1:0] pick_edge_value();
    case ($urandom_range(2))
      0: return '0;
      1: return cst_pkg::Q_ONE;
      default: return REG_MAX;
    endcase
  endfunction

  task automatic apply_profile(input profile_e kind);
    case (kind)
      PROFILE_ALWAYS:
        // Ratio at or below one makes every pass trigger.
        write_registers(cst_pkg::REG_W'($urandom_range(1, 4096)),
                        cst_pkg::REG_W'($urandom_range(cst_pkg::Q_ONE)),
                        cst_pkg::REG_W'($urandom), cst_pkg::REG_W'($urandom),
                        cst_pkg::REG_W'($urandom));
      PROFILE_TUNED:
        // Thresholds near typical peaks, so both verdicts occur.
        write_registers(cst_pkg::REG_W'($urandom_range(1, 4096)),
                        cst_pkg::REG_W'($urandom_range(cst_pkg::Q_ONE + 1, 196608)),
                        cst_pkg::REG_W'($urandom_range(1 << 16, 1 << 20)),
                        cst_pkg::REG_W'($urandom_range(1 << 14, 1 << 18)),
                        cst_pkg::REG_W'($urandom_range(1 << 15, 3 << 16)));
      PROFILE_WILD:
        write_registers(cst_pkg::REG_W'($urandom), cst_pkg::REG_W'($urandom),
                        cst_pkg::REG_W'($urandom), cst_pkg::REG_W'($urandom),
                        cst_pkg::REG_W'($urandom));
      default:
        write_registers(pick_edge_value(), pick_edge_value(), pick_edge_value(),
                        pick_edge_value(), pick_edge_value());
    endcase
  endtask

  // Reset configuration: a zero time step leaves the peak at zero, and a ratio
  // of one always asks for a search.
  task automatic test_reset_defaults();
    send_particle(3, VEL_MAX, VEL_MIN, 32'sd1, 1'b0);
    send_particle(IDX_LAST, -32'sd1, VEL_MAX, VEL_MIN, 1'b1);
    settle();
  endtask

  // Unit time step so each step equals the velocity; repeated extremes drive the
  // sums into both saturation limits, and the absolute value of the minimum too.
  task automatic test_saturation();
    write_registers(cst_pkg::Q_ONE, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    send_particle(0, VEL_MAX, VEL_MIN, 0, 1'b0);
    send_particle(IDX_LAST, VEL_MIN, VEL_MAX, 32'sd1, 1'b0);
    send_particle(0, VEL_MAX, VEL_MIN, -32'sd1, 1'b1);
    send_particle(0, 0, 0, 0, 1'b1);
    settle();
  endtask

  // Largest time step with velocities of one LSB shows the rounding toward minus
  // infinity. No search is triggered, so the next pass sees the kept value, and
  // a fresh row shows that the peak starts again from zero.
  task automatic test_rounding();
    write_registers(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
    send_particle(5, 32'sd1, -32'sd1, 0, 1'b0);
    send_particle(5, -32'sd1, -32'sd1, 32'sd1, 1'b1);
    send_particle(5, 0, 0, 0, 1'b1);
    send_particle(6, 0, 0, 0, 1'b1);
    settle();
  endtask

  // A triggered pass must clear the stored displacement of row 5.
  task automatic test_epoch_clear();
    write_registers(cst_pkg::Q_ONE, '0, '0, '0, cst_pkg::Q_ONE);
    send_particle(5, 0, 0, 0, 1'b1);
    send_particle(5, 0, 0, 0, 1'b1);
    settle();
  endtask

  // Register extremes and the exact boundaries of both limits.
  task automatic test_config_extremes();
    write_registers('0, '0, '0, '0, '0);
    send_particle(9, VEL_MAX, VEL_MAX, VEL_MAX, 1'b1);
    settle();
    // A zero search factor makes the factor limit zero.
    write_registers(cst_pkg::Q_ONE, REG_MAX, REG_MAX, REG_MAX, '0);
    send_particle(10, 32'sd7, 0, 0, 1'b1);
    settle();
    // A zero diameter does the same.
    write_registers(cst_pkg::Q_ONE, REG_MAX, REG_MAX, '0, REG_MAX);
    send_particle(11, 32'sd7, 0, 0, 1'b1);
    settle();
    // Ratio 1.5, factor 1.0, diameter 1.0: the factor limit sits at a peak of 0.25.
    write_registers(cst_pkg::Q_ONE, cst_pkg::REG_W'(98304), REG_MAX, cst_pkg::Q_ONE,
                    cst_pkg::Q_ONE);
    send_particle(20, 32'sd16383, 0, 0, 1'b1);
    send_particle(21, 32'sd16384, 0, 0, 1'b1);
    settle();
    // Cell 2.0 and diameter 1.0 put the cell limit at a peak of 1.5; the factor
    // limit is out of reach.
    write_registers(cst_pkg::Q_ONE, REG_MAX, cst_pkg::REG_W'(131072), cst_pkg::Q_ONE,
                    REG_MAX);
    send_particle(22, 0, 32'sd98303, 0, 1'b1);
    send_particle(23, 0, 0, 32'sd98304, 1'b1);
    settle();
  endtask

  // Single-particle passes that all trigger, enough to wrap the epoch tag. Row
  // k mod 256 is revisited exactly 256 triggers later, where a stale tag would
  // show up as a leftover displacement.
  task automatic test_epoch_wrap();
    int unsigned k;
    write_registers(cst_pkg::REG_W'($urandom_range(1, 1 << 16)), '0,
                    cst_pkg::REG_W'($urandom), cst_pkg::REG_W'($urandom),
                    cst_pkg::REG_W'($urandom));
    for (k = 0; k < WRAP_PASSES; k++) begin
      send_particle(cst_pkg::IDX_W'(k % 256), pick_velocity(), pick_velocity(),
                    pick_velocity(), 1'b1);
    end
    settle();
  endtask

  // Random phases: a fresh configuration, several passes of random length, then
  // a drain. One phase runs with no idling on either side.
  task automatic test_random_passes();
    int unsigned phase;
    int unsigned passes;
    int unsigned length;
    int unsigned n;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      no_idling = (phase == QUIET_PHASE);
      apply_profile(profile_e'($urandom_range(int'(PROFILE_EDGES))));
      passes = no_idling ? 20 : $urandom_range(3, 8);
      repeat (passes) begin
        length = $urandom_range(1, 12);
        for (n = 1; n <= length; n++) begin
          send_particle(pick_index(), pick_velocity(), pick_velocity(), pick_velocity(),
                        n == length);
        end
      end
      settle();
      phase++;
    end
    no_idling = 1'b0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = cst_pkg::CFG_TIME_STEP;
    cfg_data_i           = '0;
    in_if.valid          = 1'b0;
    in_if.particle_index = '0;
    in_if.velocity_x     = '0;
    in_if.velocity_y     = '0;
    in_if.velocity_z     = '0;
    in_if.pass_end       = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The clearing pass after reset holds off input; the handshake absorbs it.
    test_reset_defaults();
    test_saturation();
    test_rounding();
    test_epoch_clear();
    test_config_extremes();
    test_epoch_wrap();
    test_random_passes();
    settle();

    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
